// ===== src/tai_cal_pkg.sv =====
// Shared types and constants for the TAI93 to UTC calendar converter.
// No dependencies; imported by tai_cal_civil and tai_seconds_to_utc_calendar.
package tai_cal_pkg;

    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [3:0]         entry_index;
        logic signed [35:0] whole_seconds;
        logic [19:0]        fraction_us;
    } in_item_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millis;
        logic        leap_strike;
        logic        negative_time;
    } out_item_t;

    // time-of-day fields riding along with the date pipeline
    typedef struct packed {
        logic        negative_time;
        logic        leap_strike;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millis;
    } side_t;

    localparam logic [35:0] UNIX_OFFSET   = 36'd725846400;
    localparam logic [36:0] SEC_PER_DAY   = 37'd86400;
    localparam logic [16:0] SEC_PER_MIN   = 17'd60;
    localparam logic [10:0] MIN_PER_HOUR  = 11'd60;
    localparam logic [19:0] FRAC_MAX      = 20'd999999;
    localparam logic [19:0] FRAC_ROUND    = 20'd500;
    localparam logic [5:0]  INSERTED_SEC  = 6'd60;
    localparam logic [20:0] CIVIL_SHIFT   = 21'd719468;
    localparam logic [20:0] DAYS_PER_ERA  = 21'd146097;
    localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
    localparam logic [12:0] YEARS_PER_ERA = 13'd400;

    // Reciprocal multipliers: floor(x/D) == (x*M) >> K for x < 2**N,
    // with K = N + clog2(D) and M = ceil(2**K / D).
    localparam int MS_K   = 30;  // x < 2**20, D = 1000
    localparam int DAY_K  = 39;  // x < 2**29, D = 675 (86400 >> 7)
    localparam int MIN_K  = 23;  // x < 2**17, D = 60
    localparam int HR_K   = 17;  // x < 2**11, D = 60
    localparam int ERA_K  = 39;  // x < 2**21, D = 146097
    localparam int C4_K   = 29;  // x < 2**18, D = 1460
    localparam int C100_K = 34;  // x < 2**18, D = 36524
    localparam int Y_K    = 27;  // x < 2**18, D = 365
    localparam int H_K    = 16;  // x < 2**9,  D = 100
    localparam int MP_K   = 19;  // x < 2**11, D = 153
    localparam int D5_K   = 14;  // x < 2**11, D = 5

    localparam logic [31:0] MS_M   = 32'(((64'd1 << MS_K)   + 64'd999)    / 64'd1000);
    localparam logic [31:0] DAY_M  = 32'(((64'd1 << DAY_K)  + 64'd674)    / 64'd675);
    localparam logic [31:0] MIN_M  = 32'(((64'd1 << MIN_K)  + 64'd59)     / 64'd60);
    localparam logic [31:0] HR_M   = 32'(((64'd1 << HR_K)   + 64'd59)     / 64'd60);
    localparam logic [31:0] ERA_M  = 32'(((64'd1 << ERA_K)  + 64'd146096) / 64'd146097);
    localparam logic [31:0] C4_M   = 32'(((64'd1 << C4_K)   + 64'd1459)   / 64'd1460);
    localparam logic [31:0] C100_M = 32'(((64'd1 << C100_K) + 64'd36523)  / 64'd36524);
    localparam logic [31:0] Y_M    = 32'(((64'd1 << Y_K)    + 64'd364)    / 64'd365);
    localparam logic [31:0] H_M    = 32'(((64'd1 << H_K)    + 64'd99)     / 64'd100);
    localparam logic [31:0] MP_M   = 32'(((64'd1 << MP_K)   + 64'd152)    / 64'd153);
    localparam logic [31:0] D5_M   = 32'(((64'd1 << D5_K)   + 64'd4)      / 64'd5);

endpackage

// ===== src/tai_cal_civil.sv =====
// Day count to proleptic Gregorian date, eight register stages.
// Depends on tai_cal_pkg; also aligns and finishes the time-of-day fields.
module tai_cal_civil (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [19:0]           days,
    input  tai_cal_pkg::side_t    side,
    output logic                  out_valid,
    output tai_cal_pkg::out_item_t out_item
);
    import tai_cal_pkg::*;

    logic [7:0]  valid_reg;
    side_t       side_reg [7];
    logic [3:0]  era_reg [7];

    logic [20:0] c1_z_reg;
    logic [17:0] c2_doe_reg, c3_doe_reg, c4_doe_reg, c5_doe_reg;
    logic [6:0]  c3_q4_reg;
    logic [2:0]  c3_q100_reg;
    logic        c3_q400_reg;
    logic [8:0]  c4_yoe_reg, c5_yoe_reg, c6_yoe_reg, c7_yoe_reg;
    logic [1:0]  c5_h_reg;
    logic [8:0]  c6_doy_reg, c7_doy_reg;
    logic [3:0]  c7_mp_reg;
    out_item_t   out_reg;

    // stage combinational values
    logic [20:0] z_next;
    logic [52:0] era_prod;
    logic [17:0] doe_next;
    logic [49:0] q4_prod, q100_prod, yoe_prod;
    logic [17:0] t_yoe;
    logic [40:0] h_prod;
    logic [17:0] yday_base;
    logic [10:0] mp_x;
    logic [42:0] mp_prod;
    logic [10:0] d5_x;
    logic [42:0] d5_prod;
    logic [8:0]  d5_q;
    logic [3:0]  month_next;
    logic [12:0] year_full;
    out_item_t   out_next;

    always_comb
    begin
        z_next    = 21'(days) + CIVIL_SHIFT;
        era_prod  = 53'(z_next) * 53'(ERA_M);
        doe_next  = 18'(c1_z_reg - 21'(era_reg[0]) * DAYS_PER_ERA);
        q4_prod   = 50'(c2_doe_reg) * 50'(C4_M);
        q100_prod = 50'(c2_doe_reg) * 50'(C100_M);
        t_yoe     = c3_doe_reg - 18'(c3_q4_reg) + 18'(c3_q100_reg) - 18'(c3_q400_reg);
        yoe_prod  = 50'(t_yoe) * 50'(Y_M);
        h_prod    = 41'(c4_yoe_reg) * 41'(H_M);
        yday_base = 18'(c5_yoe_reg) * 18'd365 + 18'(c5_yoe_reg[8:2]) - 18'(c5_h_reg);
        mp_x      = 11'(c6_doy_reg) * 11'd5 + 11'd2;
        mp_prod   = 43'(mp_x) * 43'(MP_M);
        d5_x      = 11'(c7_mp_reg) * 11'd153 + 11'd2;
        d5_prod   = 43'(d5_x) * 43'(D5_M);
        d5_q      = d5_prod[D5_K +: 9];
        month_next = (c7_mp_reg < 4'd10) ? c7_mp_reg + 4'd3 : c7_mp_reg - 4'd9;
        year_full = 13'(c7_yoe_reg) + 13'(era_reg[6]) * YEARS_PER_ERA
                  + 13'(month_next <= 4'd2);

        out_next = '0;
        if (side_reg[6].negative_time)
        begin
            out_next.negative_time = 1'b1;
        end
        else
        begin
            out_next.year        = year_full[11:0];
            out_next.month       = month_next;
            out_next.day         = 5'(c7_doy_reg - d5_q + 9'd1);
            out_next.hour        = side_reg[6].hour;
            out_next.minute      = side_reg[6].minute;
            out_next.second      = side_reg[6].second;
            out_next.millis      = side_reg[6].millis;
            out_next.leap_strike = side_reg[6].leap_strike;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side;
        era_reg[0]  <= era_prod[ERA_K +: 4];
        for (int s = 1; s < 7; s++)
        begin
            side_reg[s] <= side_reg[s-1];
            era_reg[s]  <= era_reg[s-1];
        end
        c1_z_reg    <= z_next;
        c2_doe_reg  <= doe_next;
        c3_doe_reg  <= c2_doe_reg;
        c3_q4_reg   <= q4_prod[C4_K +: 7];
        c3_q100_reg <= q100_prod[C100_K +: 3];
        c3_q400_reg <= (c2_doe_reg == ERA_LAST_DAY);
        c4_doe_reg  <= c3_doe_reg;
        c4_yoe_reg  <= yoe_prod[Y_K +: 9];
        c5_doe_reg  <= c4_doe_reg;
        c5_yoe_reg  <= c4_yoe_reg;
        c5_h_reg    <= h_prod[H_K +: 2];
        c6_yoe_reg  <= c5_yoe_reg;
        c6_doy_reg  <= 9'(c5_doe_reg - yday_base);
        c7_yoe_reg  <= c6_yoe_reg;
        c7_doy_reg  <= c6_doy_reg;
        c7_mp_reg   <= mp_prod[MP_K +: 4];
        out_reg     <= out_next;
    end

    assign out_valid = valid_reg[7];
    assign out_item  = out_reg;

endmodule

// ===== src/tai_seconds_to_utc_calendar.sv =====
// Top level of the TAI93 seconds to UTC calendar converter.
// Depends on tai_cal_pkg and tai_cal_civil.
//
// For a convert item accepted at a start edge, result_valid rises together with
// the result as the item leaves the output register of tai_cal_civil; the
// strobe lasts one cycle and the receiver cannot hold it off. The converter is
// a 15-stage pipeline (leap lookup, seconds-to-day split, time of day, then the
// Gregorian date in tai_cal_civil) and takes a new item every cycle, so busy
// stays low. A load item writes one leap table slot at its start edge and
// yields no result; a convert accepted in the next cycle already sees the new
// entry. Table slots are undefined until loaded, and leap_count
// (cfg_wr_en/cfg_wr_data) must only be changed while the pipeline is empty.
// Negative inputs return all zeros with negative_time set.
module tai_seconds_to_utc_calendar #(
    parameter int LEAP_ENTRIES = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tai_cal_pkg::in_item_t  item,
    input  logic                   cfg_wr_en,
    input  logic [4:0]             cfg_wr_data,
    output logic                   result_valid,
    output tai_cal_pkg::out_item_t result
);
    import tai_cal_pkg::*;

    localparam int LCNT_W = $clog2(LEAP_ENTRIES + 1);

    logic        accept;
    logic [4:0]  leap_count_reg;
    logic [34:0] leap_table_reg [LEAP_ENTRIES];

    // stage A: captured item
    logic        a_valid_reg, a_neg_reg;
    logic [34:0] a_whole_reg;
    logic [19:0] a_msx_reg;
    logic [19:0] frac_sat;
    // stage B: table compares, millisecond product
    logic        b_valid_reg, b_neg_reg;
    logic [34:0] b_whole_reg;
    logic [LEAP_ENTRIES-1:0] b_ge_reg, b_ge1_reg, ge_next, ge1_next;
    logic [51:0] b_msprod_reg;
    // stage C: leap count applied
    logic        c_valid_reg, c_neg_reg, c_strike_reg;
    logic [35:0] c_u_reg, u_next;
    logic [9:0]  c_ms_reg;
    logic [LCNT_W-1:0] lcnt;
    logic        strike;
    // stage D: day product
    logic        d_valid_reg, d_neg_reg, d_strike_reg;
    logic [35:0] d_u_reg;
    logic [9:0]  d_ms_reg;
    logic [60:0] d_dayprod_reg;
    // stage E: day count and second of day
    logic        e_valid_reg, e_neg_reg, e_strike_reg;
    logic [9:0]  e_ms_reg;
    logic [19:0] e_days_reg, days_next;
    logic [16:0] e_rem_reg;
    logic [36:0] day_sec;
    // stage F: minute of day
    logic        f_valid_reg, f_neg_reg, f_strike_reg;
    logic [9:0]  f_ms_reg;
    logic [19:0] f_days_reg;
    logic [16:0] f_rem_reg;
    logic [10:0] f_mins_reg;
    logic [48:0] min_prod;
    // stage G: second and hour
    logic        g_valid_reg, g_neg_reg, g_strike_reg;
    logic [9:0]  g_ms_reg;
    logic [19:0] g_days_reg;
    logic [10:0] g_mins_reg;
    logic [5:0]  g_sec_reg;
    logic [4:0]  g_hour_reg;
    logic [42:0] hr_prod;
    side_t       side;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leap_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            leap_count_reg <= cfg_wr_data;
        end
    end

    // Load slots past the table are dropped.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < LEAP_ENTRIES; j++)
        begin
            if (accept && item.opcode == OP_LOAD && {3'b000, item.entry_index} == 7'(j))
            begin
                leap_table_reg[j] <= item.whole_seconds[34:0];
            end
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept && item.opcode == OP_CONVERT;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
        end
    end

    always_comb
    begin
        frac_sat = (item.fraction_us > FRAC_MAX) ? FRAC_MAX : item.fraction_us;

        // entry j counts only below leap_count; leap_count past the table
        // size therefore covers the whole table
        for (int j = 0; j < LEAP_ENTRIES; j++)
        begin
            ge_next[j]  = (7'(j) < {2'b00, leap_count_reg})
                        && (a_whole_reg >= leap_table_reg[j]);
            ge1_next[j] = (7'(j) < {2'b00, leap_count_reg})
                        && (({1'b0, a_whole_reg} + 36'd1) >= {1'b0, leap_table_reg[j]});
        end

        // Highest entry within one second decides; short of it by one second
        // means the item sits inside that inserted second.
        lcnt   = '0;
        strike = 1'b0;
        for (int j = 0; j < LEAP_ENTRIES; j++)
        begin
            if (b_ge1_reg[j])
            begin
                lcnt   = b_ge_reg[j] ? LCNT_W'(j + 1) : LCNT_W'(j);
                strike = !b_ge_reg[j];
            end
        end
        u_next = {1'b0, b_whole_reg} + UNIX_OFFSET - 36'(lcnt) - 36'(strike);

        days_next = d_dayprod_reg[DAY_K +: 20];
        day_sec   = 37'(days_next) * SEC_PER_DAY;
        min_prod  = 49'(e_rem_reg) * 49'(MIN_M);
        hr_prod   = 43'(f_mins_reg) * 43'(HR_M);

        side.negative_time = g_neg_reg;
        side.leap_strike   = g_strike_reg;
        side.hour          = g_hour_reg;
        side.minute        = 6'(g_mins_reg - 11'(g_hour_reg) * MIN_PER_HOUR);
        side.second        = g_strike_reg ? INSERTED_SEC : g_sec_reg;
        side.millis        = g_ms_reg;
    end

    always_ff @(posedge clk)
    begin
        a_neg_reg     <= item.whole_seconds[35];
        a_whole_reg   <= item.whole_seconds[34:0];
        a_msx_reg     <= frac_sat + FRAC_ROUND;

        b_neg_reg     <= a_neg_reg;
        b_whole_reg   <= a_whole_reg;
        b_ge_reg      <= ge_next;
        b_ge1_reg     <= ge1_next;
        b_msprod_reg  <= 52'(a_msx_reg) * 52'(MS_M);

        c_neg_reg     <= b_neg_reg;
        c_strike_reg  <= strike;
        c_u_reg       <= u_next;
        c_ms_reg      <= b_msprod_reg[MS_K +: 10];

        d_neg_reg     <= c_neg_reg;
        d_strike_reg  <= c_strike_reg;
        d_u_reg       <= c_u_reg;
        d_ms_reg      <= c_ms_reg;
        d_dayprod_reg <= 61'(c_u_reg[35:7]) * 61'(DAY_M);

        e_neg_reg     <= d_neg_reg;
        e_strike_reg  <= d_strike_reg;
        e_ms_reg      <= d_ms_reg;
        e_days_reg    <= days_next;
        e_rem_reg     <= 17'(d_u_reg - day_sec[35:0]);

        f_neg_reg     <= e_neg_reg;
        f_strike_reg  <= e_strike_reg;
        f_ms_reg      <= e_ms_reg;
        f_days_reg    <= e_days_reg;
        f_rem_reg     <= e_rem_reg;
        f_mins_reg    <= min_prod[MIN_K +: 11];

        g_neg_reg     <= f_neg_reg;
        g_strike_reg  <= f_strike_reg;
        g_ms_reg      <= f_ms_reg;
        g_days_reg    <= f_days_reg;
        g_mins_reg    <= f_mins_reg;
        g_sec_reg     <= 6'(f_rem_reg - 17'(f_mins_reg) * SEC_PER_MIN);
        g_hour_reg    <= hr_prod[HR_K +: 5];
    end

    tai_cal_civil u_civil (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid_reg),
        .days      (g_days_reg),
        .side      (side),
        .out_valid (result_valid),
        .out_item  (result)
    );

    ap_strike_sixty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.leap_strike |->
            result.second == INSERTED_SEC && !result.negative_time)
        else $error("leap strike without second 60");

    ap_negative_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.negative_time |->
            result.year == 12'd0 && result.month == 4'd0 && result.day == 5'd0
            && result.millis == 10'd0 && !result.leap_strike)
        else $error("negative time with nonzero fields");

    ap_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.negative_time |->
            result.month >= 4'd1 && result.month <= 4'd12
            && result.day >= 5'd1 && result.day <= 5'd31)
        else $error("date out of range");

    ap_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result.hour <= 5'd23 && result.minute <= 6'd59 && result.millis <= 10'd1000)
        else $error("time of day out of range");

endmodule

// ===== tb/tb_tai_seconds_to_utc_calendar.sv =====
// Self-checking testbench for tai_seconds_to_utc_calendar (TAI93 seconds to UTC date/time).
// Depends on tai_cal_pkg and the converter RTL; a local calendar predictor scores every untyped result.
`timescale 1ns / 100ps

module tb_tai_seconds_to_utc_calendar;
    import tai_cal_pkg::*;

    localparam int N_SLOTS  = 16;    // leap table depth of the dut
    localparam int LATENCY  = 15;    // start edge to the edge that takes the result
    localparam int WD_LIMIT = 2000;  // cycles with no item or result accepted
    localparam int N_PHASES = 7;
    localparam int PHASE_ITEMS = 170;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [4:0] cfg_wr_data = '0;
    in_item_t   item = '0;
    logic       busy;
    logic       result_valid;
    out_item_t  result;

    tai_seconds_to_utc_calendar #(.LEAP_ENTRIES(N_SLOTS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #6 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: our own copy of the leap table and leap_count.
    // ---------------------------------------------------------------
    logic [34:0] leap_tab [N_SLOTS];
    logic [4:0]  leap_count_m = '0;
    out_item_t   utc_due [$];        // expected results, oldest first

    int n_conv = 0, n_loads = 0, n_strikes = 0, n_neg = 0, n_ms1000 = 0;
    int n_results = 0, mismatches = 0, wd_count = 0;

    // Expected calendar result of one convert item, given current table/count.
    function automatic out_item_t to_utc(in_item_t it);
        out_item_t r;
        longint w, e, u, days, rem, z, era, doe, yoe, doy, mp, yy, frac, ms;
        int n, lcnt, strike;
        r = '0;
        w = longint'(it.whole_seconds);
        if (w < 0)
        begin
            r.negative_time = 1'b1;
            return r;
        end
        // count above table depth is clamped
        n = (leap_count_m > N_SLOTS) ? N_SLOTS : int'(leap_count_m);
        lcnt = 0;
        strike = 0;
        // highest entry reached; one second short of an entry is the leap second
        for (int j = n - 1; j >= 0; j--)
        begin
            e = longint'({29'd0, leap_tab[j]});
            if (w >= e)
            begin
                lcnt = j + 1;
                break;
            end
            if (w + 1 >= e)
            begin
                lcnt = j;
                strike = 1;
                break;
            end
        end
        frac = (it.fraction_us > FRAC_MAX) ? longint'(FRAC_MAX) : longint'(it.fraction_us);
        ms = (frac + 500) / 1000;
        u = w + longint'(UNIX_OFFSET) - lcnt - strike;
        days = u / 86400;
        rem = u % 86400;
        // days since 1970 to proleptic Gregorian (era = 400 years)
        z = days + 719468;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        yy = yoe + era * 400;
        r.day = 5'(doy - (153 * mp + 2) / 5 + 1);
        r.month = (mp < 10) ? 4'(mp + 3) : 4'(mp - 9);
        if (r.month <= 2)
            yy = yy + 1;
        r.year = 12'(yy);
        r.hour = 5'(rem / 3600);
        r.minute = 6'((rem / 60) % 60);
        r.second = strike ? INSERTED_SEC : 6'(rem % 60);
        r.millis = 10'(ms);
        r.leap_strike = (strike != 0);
        return r;
    endfunction

    function automatic string fmt_utc(out_item_t r);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d ms=%0d strike=%0b neg=%0b",
                         r.year, r.month, r.day, r.hour, r.minute, r.second,
                         r.millis, r.leap_strike, r.negative_time);
    endfunction

    // ---------------------------------------------------------------
    // Sender side. start stays high across back-to-back items; only
    // idle() and the drain lower it.
    // ---------------------------------------------------------------
    task automatic idle(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic push_item(in_item_t it, bit typed, out_item_t want);
        out_item_t p;
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy !== 1'b0);
        if (it.opcode == OP_LOAD)
        begin
            // loads keep only the low 35 bits as an unsigned instant
            leap_tab[it.entry_index] = it.whole_seconds[34:0];
            n_loads++;
        end
        else
        begin
            p = to_utc(it);
            utc_due.push_back(typed ? want : p);
            n_conv++;
            n_strikes += p.leap_strike;
            n_neg += p.negative_time;
            n_ms1000 += (p.millis == 10'd1000);
        end
    endtask

    // Hold off until every expected item is back, then let the pipe empty.
    task automatic drain();
        start <= 1'b0;
        while (utc_due.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_leap_count(logic [4:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        leap_count_m = v;
    endtask

    // Fill every slot: ascending with mixed gaps, or fully random.
    task automatic reload_table(bit scrambled);
        in_item_t it;
        longint t;
        t = $urandom_range(0, 400000000);
        for (int k = 0; k < N_SLOTS; k++)
        begin
            it = '0;
            it.opcode = OP_LOAD;
            it.entry_index = 4'(k);
            it.fraction_us = 20'($urandom);
            case ($urandom_range(0, 3))
                0: t = t + 1;    // back-to-back leap seconds
                1: t = t + 2;
                2: t = t + $urandom_range(3, 1000);
                default: t = t + $urandom_range(1000, 200000000);
            endcase
            it.whole_seconds = scrambled ? 36'({$urandom, $urandom}) : 36'(t);
            push_item(it, 1'b0, '0);
        end
    endtask

    // Random item: mostly converts around live table entries.
    function automatic in_item_t rand_item(int live);
        in_item_t it;
        int sel, j;
        longint w;
        it = '0;
        sel = $urandom_range(0, 99);
        it.entry_index = 4'($urandom);
        if ($urandom_range(0, 3) == 0)
            it.fraction_us = 20'($urandom);            // includes the saturating range
        else
            it.fraction_us = 20'($urandom_range(0, 999999));
        it.opcode = OP_CONVERT;
        if (sel < 8)
        begin
            it.opcode = OP_LOAD;
            if ($urandom_range(0, 3) == 0)
                it.whole_seconds = 36'({$urandom, $urandom});
            else
            begin
                w = longint'({29'd0, leap_tab[it.entry_index]}) + $urandom_range(0, 4) - 2;
                it.whole_seconds = 36'(w);
            end
        end
        else if (sel < 15)
            it.whole_seconds = {1'b1, 35'({$urandom, $urandom})};
        else if (sel < 30)
            it.whole_seconds = 36'({$urandom, $urandom});
        else if (sel < 45)
            it.whole_seconds = 36'($urandom_range(0, 1600000000));
        else if (live == 0)
            it.whole_seconds = {1'b0, 35'({$urandom, $urandom})};
        else
        begin
            j = $urandom_range(0, live - 1);
            w = longint'({29'd0, leap_tab[j]}) + $urandom_range(0, 6) - 3;
            it.whole_seconds = 36'(w);
        end
        return it;
    endfunction

    // ---------------------------------------------------------------
    // Directed rows. Typed expectations only where obvious; the rest
    // (chk = 0) are scored by the predictor.
    // ---------------------------------------------------------------
    typedef struct {
        in_item_t  it;
        bit        chk;
        out_item_t want;
    } dir_row_t;

    localparam int N_DIR = 24;
    dir_row_t dir_tab [N_DIR] = '{
        // epoch of TAI93, empty table
        '{'{OP_CONVERT, 4'd0, 36'd0, 20'd0}, 1'b1,
          '{12'd1993, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0, 1'b0}},
        // millis rounds up to 1000
        '{'{OP_CONVERT, 4'd15, 36'd0, 20'd999999}, 1'b1,
          '{12'd1993, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd1000, 1'b0, 1'b0}},
        // fraction above range saturates
        '{'{OP_CONVERT, 4'd0, 36'd0, 20'hFFFFF}, 1'b1,
          '{12'd1993, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd1000, 1'b0, 1'b0}},
        // rounding boundary at half a millisecond
        '{'{OP_CONVERT, 4'd0, 36'd499, 20'd500}, 1'b1,
          '{12'd1993, 4'd1, 5'd1, 5'd0, 6'd8, 6'd19, 10'd1, 1'b0, 1'b0}},
        '{'{OP_CONVERT, 4'd0, 36'd86399, 20'd499}, 1'b1,
          '{12'd1993, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 10'd0, 1'b0, 1'b0}},
        // negative time: all zero but the flag
        '{'{OP_CONVERT, 4'd0, 36'hF_FFFF_FFFF, 20'd0}, 1'b1,
          '{12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0, 1'b1}},
        '{'{OP_CONVERT, 4'd15, 36'h8_0000_0000, 20'hFFFFF}, 1'b1,
          '{12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0, 1'b1}},
        // largest positive time
        '{'{OP_CONVERT, 4'd0, 36'h7_FFFF_FFFF, 20'd500000}, 1'b0, '0},
        // table load, ascending leap instants
        '{'{OP_LOAD, 4'd0,  36'd15638400,  20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd1,  36'd78710400,  20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd2,  36'd141782400, 20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd3,  36'd204854400, 20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd4,  36'd267926400, 20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd5,  36'd330998400, 20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd6,  36'd394070400, 20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd7,  36'd457142400, 20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd8,  36'd520214400, 20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd9,  36'd583286400, 20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd10, 36'd646358400, 20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd11, 36'd709430400, 20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd12, 36'd772502400, 20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd13, 36'd835574400, 20'd0}, 1'b0, '0},
        '{'{OP_LOAD, 4'd14, 36'd898646400, 20'd0}, 1'b0, '0},
        // sign bit set: only the low 35 bits land in the slot
        '{'{OP_LOAD, 4'd15, 36'h8_0000_0000 | 36'd961718400, 20'hFFFFF}, 1'b0, '0}
    };

    // ---------------------------------------------------------------
    // Result checker: every strobe is matched to the oldest expectation.
    // ---------------------------------------------------------------
    out_item_t want_q;

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            n_results++;
            if (utc_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %s", fmt_utc(result));
            end
            else
            begin
                want_q = utc_due.pop_front();
                if (result !== want_q)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d\n  expected %s\n  actual   %s",
                                 n_results, fmt_utc(want_q), fmt_utc(result));
                end
            end
        end
    end

    // Watchdog: stall detector on both handshakes.
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || result_valid === 1'b1)
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT)
        begin
            $display("ERROR: no progress for %0d cycles", WD_LIMIT);
            $display("tb_tai_seconds_to_utc_calendar failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        int phase_count [N_PHASES];
        int live;
        bit quiet;
        phase_count = '{16, 1, 31, 0, 8, 17, 15};
        for (int k = 0; k < N_SLOTS; k++)
            leap_tab[k] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs with leap_count = 0 from reset
        for (int i = 0; i < N_DIR; i++)
            push_item(dir_tab[i].it, dir_tab[i].chk, dir_tab[i].want);

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
                reload_table(p == 3);
            set_leap_count(5'(phase_count[p]));
            live = (phase_count[p] > N_SLOTS) ? N_SLOTS : phase_count[p];
            quiet = (p == N_PHASES - 1);   // closing phase runs flat out
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2)
                    drain();               // let the pipe run dry mid-phase
                push_item(rand_item(live), 1'b0, '0);
                if (!quiet && !(k > 100 && k < 130) && $urandom_range(0, 6) == 0)
                    idle($urandom_range(1, 9));
            end
        end

        drain();
        mismatches += utc_due.size();

        $display("Ran %0d converts and %0d table loads over %0d leap_count settings;",
                 n_conv, n_loads, N_PHASES + 1);
        $display("  %0d in a leap second, %0d negative, %0d with 1000 ms, %0d mismatches.",
                 n_strikes, n_neg, n_ms1000, mismatches);
        if (mismatches == 0)
            $display("tb_tai_seconds_to_utc_calendar passed");
        else
            $display("tb_tai_seconds_to_utc_calendar failed");
        $finish;
    end

endmodule
